// ===== sv/bike_safety_light_classifier_defines.svh =====
// Assertion macros for the bike safety light classifier.
// Used by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef BIKE_SAFETY_LIGHT_CLASSIFIER_DEFINES_SVH
`define BIKE_SAFETY_LIGHT_CLASSIFIER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define BSLC_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define BSLC_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bslc_pkg.sv =====
// Shared constants, codes and types for the bike safety light classifier.
// No dependencies; the window, class and top-level files refer to it by scoped names.
package bslc_pkg;

  // acceleration window depth and derived widths
  localparam int WIN_DEPTH = 8;
  localparam int WIN_SH    = $clog2(WIN_DEPTH);
  localparam int WIN_IDX_W = (WIN_DEPTH > 1) ? WIN_SH : 1;
  localparam int SUM_W     = 16 + WIN_SH;
  localparam bit WIN_POW2  = ((1 << WIN_SH) == WIN_DEPTH);

  // reciprocal divide for a depth that is not a power of two:
  // u = sum + WIN_DEPTH*32768 is non-negative, floor(u/N) = (u*M) >> K exactly
  localparam int      DIV_K   = SUM_W + WIN_SH;
  localparam int      DIV_M_W = SUM_W + 2;
  localparam longint  DIV_M   = ((longint'(1) << DIV_K) + WIN_DEPTH - 1) / WIN_DEPTH;
  localparam longint  DIV_OFF = longint'(WIN_DEPTH) * 32768;

  // request codes
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_EVAL   = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  // safety class codes
  localparam logic [2:0] CLS_IDLE     = 3'd0;
  localparam logic [2:0] CLS_ERROR    = 3'd1;
  localparam logic [2:0] CLS_BRAKING  = 3'd2;
  localparam logic [2:0] CLS_MOVING   = 3'd3;
  localparam logic [2:0] CLS_LOWLIGHT = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_TEMP_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_BRAKE_THR   = 2'd1;
  localparam logic [1:0] CFG_LIGHT_THR   = 2'd2;
  localparam logic [1:0] CFG_FLASH_LIMIT = 2'd3;

  localparam logic [7:0] FLASH_MAX = 8'hFF;

  typedef struct packed {
    logic signed [15:0] temp_limit;
    logic signed [15:0] brake_threshold;
    logic        [15:0] light_threshold;
    logic        [7:0]  flash_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    temp_limit:      16'sd5120,
    brake_threshold: -16'sd819,
    light_threshold: 16'd7680,
    flash_limit:     8'd10
  };

  // per-item commit strobes
  typedef struct packed {
    logic sample;
    logic eval;
    logic tick;
  } ctl_t;

  // classifier state as seen on the result channel
  typedef struct packed {
    logic [2:0]         cls;
    logic               front;
    logic               rear;
    logic signed [15:0] avg;
    logic [7:0]         flash_cnt;
  } stat_t;

endpackage

// ===== sv/bslc_if.sv =====
// Valid/ready channel interfaces for the classifier input and result items.
// Stand-alone; widths follow the item fields.
interface bslc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [15:0] fwd_accel;
  logic signed [15:0] temperature;
  logic [15:0]        ambient_light;

  modport source (output valid, req_type, fwd_accel, temperature, ambient_light,
                  input ready);
  modport sink   (input valid, req_type, fwd_accel, temperature, ambient_light,
                  output ready);
endinterface

interface bslc_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         safety_class;
  logic               front_lamp;
  logic               rear_lamp;
  logic signed [15:0] average_accel;
  logic [7:0]         flash_count;

  modport source (output valid, safety_class, front_lamp, rear_lamp, average_accel,
                  flash_count, input ready);
  modport sink   (input valid, safety_class, front_lamp, rear_lamp, average_accel,
                  flash_count, output ready);
endinterface

// ===== sv/bslc_window.sv =====
// Acceleration window: circular sample store, running sum and floor average.
// Depends on bslc_pkg.
module bslc_window (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 sample_en,
  input  logic signed [15:0]   sample,
  output logic signed [15:0]   avg
);

  logic signed [15:0]                 win_r [bslc_pkg::WIN_DEPTH];
  logic signed [bslc_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [bslc_pkg::WIN_IDX_W-1:0]     slot_r, slot_nxt;

  // replace the oldest entry and adjust the sum
  always_comb begin
    sum_nxt = sum_r - bslc_pkg::SUM_W'(win_r[slot_r]) + bslc_pkg::SUM_W'(sample);
    if (slot_r == bslc_pkg::WIN_IDX_W'(bslc_pkg::WIN_DEPTH - 1)) begin
      slot_nxt = '0;
    end else begin
      slot_nxt = slot_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bslc_pkg::WIN_DEPTH; i++) begin
        win_r[i] <= '0;
      end
      sum_r  <= '0;
      slot_r <= '0;
    end else if (sample_en) begin
      win_r[slot_r] <= sample;
      sum_r         <= sum_nxt;
      slot_r        <= slot_nxt;
    end
  end

  // floor(sum / depth)
  if (bslc_pkg::WIN_POW2) begin : g_shift
    assign avg = sum_r[bslc_pkg::SUM_W-1:bslc_pkg::WIN_SH];
  end else begin : g_recip
    logic [bslc_pkg::SUM_W-1:0]                    u;
    logic [bslc_pkg::SUM_W+bslc_pkg::DIV_M_W-1:0]  prod;
    logic [15:0]                                   q;
    // bias to non-negative, multiply by reciprocal, unbias by flipping the top bit
    assign u    = bslc_pkg::SUM_W'(sum_r) + bslc_pkg::SUM_W'(bslc_pkg::DIV_OFF);
    assign prod = (bslc_pkg::SUM_W + bslc_pkg::DIV_M_W)'(u)
                * (bslc_pkg::SUM_W + bslc_pkg::DIV_M_W)'(bslc_pkg::DIV_M);
    assign q    = prod[bslc_pkg::DIV_K +: 16];
    assign avg  = {~q[15], q[14:0]};
  end

endmodule

// ===== sv/bslc_class.sv =====
// Safety class state machine with flash counter, lamp drives and stored average.
// Depends on bslc_pkg.
module bslc_class (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bslc_pkg::ctl_t         ctl,
  input  bslc_pkg::cfg_t         cfg,
  input  logic signed [15:0]     avg_in,
  input  logic signed [15:0]     temperature,
  input  logic [15:0]            ambient_light,
  output bslc_pkg::stat_t        stat
);

  logic [2:0]         cls_r, cls_nxt;
  logic               front_r, front_nxt;
  logic               rear_r, rear_nxt;
  logic signed [15:0] avg_r, avg_nxt;
  logic [7:0]         cnt_r, cnt_nxt;
  logic               hot;
  logic               cnt_done;
  logic [7:0]         cnt_inc;

  assign hot      = temperature > cfg.temp_limit;
  assign cnt_done = cnt_r >= cfg.flash_limit;
  assign cnt_inc  = (cnt_r == bslc_pkg::FLASH_MAX) ? cnt_r : cnt_r + 8'd1;

  // class rules on evaluate, flashing on tick
  always_comb begin
    cls_nxt   = cls_r;
    front_nxt = front_r;
    rear_nxt  = rear_r;
    avg_nxt   = avg_r;
    cnt_nxt   = cnt_r;
    if (ctl.eval) begin
      avg_nxt = avg_in;
      unique case (cls_r)
        bslc_pkg::CLS_IDLE: begin
          cnt_nxt = '0;
          if (hot) begin
            cls_nxt = bslc_pkg::CLS_ERROR;
          end else if (avg_in < cfg.brake_threshold) begin
            cls_nxt = bslc_pkg::CLS_BRAKING;
          end else if (ambient_light < cfg.light_threshold) begin
            cls_nxt = bslc_pkg::CLS_LOWLIGHT;
          end else begin
            cls_nxt = bslc_pkg::CLS_MOVING;
          end
        end
        bslc_pkg::CLS_ERROR: begin
          if (cnt_done && !hot) begin
            cls_nxt = bslc_pkg::CLS_IDLE;
            cnt_nxt = '0;
          end
        end
        bslc_pkg::CLS_BRAKING: begin
          if (cnt_done) begin
            cls_nxt = bslc_pkg::CLS_IDLE;
            cnt_nxt = '0;
          end
        end
        bslc_pkg::CLS_MOVING: begin
          front_nxt = 1'b0;
          rear_nxt  = 1'b0;
          cnt_nxt   = '0;
          cls_nxt   = bslc_pkg::CLS_IDLE;
        end
        bslc_pkg::CLS_LOWLIGHT: begin
          front_nxt = 1'b1;
          rear_nxt  = 1'b1;
          cnt_nxt   = '0;
          cls_nxt   = bslc_pkg::CLS_IDLE;
        end
        default: begin
          cls_nxt = bslc_pkg::CLS_IDLE;
        end
      endcase
    end else if (ctl.tick) begin
      if (cls_r == bslc_pkg::CLS_ERROR) begin
        cnt_nxt   = cnt_inc;
        front_nxt = ~front_r;
        rear_nxt  = ~rear_r;
      end else if (cls_r == bslc_pkg::CLS_BRAKING) begin
        cnt_nxt  = cnt_inc;
        rear_nxt = ~rear_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r   <= bslc_pkg::CLS_IDLE;
      front_r <= 1'b0;
      rear_r  <= 1'b0;
      avg_r   <= '0;
      cnt_r   <= '0;
    end else begin
      cls_r   <= cls_nxt;
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      avg_r   <= avg_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign stat = '{cls: cls_r, front: front_r, rear: rear_r, avg: avg_r, flash_cnt: cnt_r};

endmodule

// ===== sv/bike_safety_light_classifier.sv =====
// Bike safety light classifier, top level.
// Path: an input transfer loads the input stage register, and its commit loads the state and result valid registers.
// Throughput: one item per cycle while no result is held; the state registers double as the result register.
// An item commits when the result slot is empty or being taken; a held result stalls commits.
// Reset (synchronous, rst_n low): window and sum zero, class idle, lamps off, count zero,
// configuration registers to their defaults, both channels empty.
`include "bike_safety_light_classifier_defines.svh"

module bike_safety_light_classifier (
  input  logic              clk,
  input  logic              rst_n,
  bslc_in_if.sink           in_chan,
  bslc_out_if.source        out_chan,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_idx,
  input  logic [15:0]       cfg_wdata
);

  bslc_pkg::cfg_t      cfg_r, cfg_nxt;
  bslc_pkg::ctl_t      ctl;
  bslc_pkg::stat_t     stat;

  logic                s1_vld_r, s1_vld_nxt;
  logic [1:0]          s1_req_r;
  logic signed [15:0]  s1_accel_r;
  logic signed [15:0]  s1_temp_r;
  logic [15:0]         s1_light_r;
  logic                out_vld_r, out_vld_nxt;
  logic                advance;
  logic                commit;
  logic                in_xfer;
  logic signed [15:0]  avg;
  logic [1:0]          lamps;
  logic [7:0]          cnt_now;
  logic                flash_tick;
  logic                moving_eval;
  logic                idle_dark;

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        bslc_pkg::CFG_TEMP_LIMIT:  cfg_nxt.temp_limit      = cfg_wdata;
        bslc_pkg::CFG_BRAKE_THR:   cfg_nxt.brake_threshold = cfg_wdata;
        bslc_pkg::CFG_LIGHT_THR:   cfg_nxt.light_threshold = cfg_wdata;
        bslc_pkg::CFG_FLASH_LIMIT: cfg_nxt.flash_limit     = cfg_wdata[7:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  // handshake: the input stage drains whenever the result slot frees up
  assign advance       = !out_vld_r || out_chan.ready;
  assign commit        = s1_vld_r && advance;
  assign in_chan.ready = !s1_vld_r || advance;
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign s1_vld_nxt    = in_xfer || (s1_vld_r && !advance);
  assign out_vld_nxt   = commit || (out_vld_r && !out_chan.ready);

  // request decode into commit strobes
  always_comb begin
    ctl = '0;
    unique case (s1_req_r)
      bslc_pkg::REQ_SAMPLE: ctl.sample = commit;
      bslc_pkg::REQ_EVAL:   ctl.eval   = commit;
      bslc_pkg::REQ_TICK:   ctl.tick   = commit;
      default:              ctl        = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r     <= bslc_pkg::CFG_RESET;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      cfg_r     <= cfg_nxt;
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // input payload register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_req_r   <= in_chan.req_type;
      s1_accel_r <= in_chan.fwd_accel;
      s1_temp_r  <= in_chan.temperature;
      s1_light_r <= in_chan.ambient_light;
    end
  end

  bslc_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .sample_en (ctl.sample),
    .sample    (s1_accel_r),
    .avg       (avg)
  );

  bslc_class u_class (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .cfg           (cfg_r),
    .avg_in        (avg),
    .temperature   (s1_temp_r),
    .ambient_light (s1_light_r),
    .stat          (stat)
  );

  // result channel shows the committed state
  assign out_chan.valid         = out_vld_r;
  assign out_chan.safety_class  = stat.cls;
  assign out_chan.front_lamp    = stat.front;
  assign out_chan.rear_lamp     = stat.rear;
  assign out_chan.average_accel = stat.avg;
  assign out_chan.flash_count   = stat.flash_cnt;

  // terms for the checks
  assign lamps       = {stat.front, stat.rear};
  assign cnt_now     = stat.flash_cnt;
  assign flash_tick  = ctl.tick && cnt_now != bslc_pkg::FLASH_MAX &&
                       (stat.cls == bslc_pkg::CLS_ERROR || stat.cls == bslc_pkg::CLS_BRAKING);
  assign moving_eval = ctl.eval && stat.cls == bslc_pkg::CLS_MOVING;
  assign idle_dark   = stat.cls == bslc_pkg::CLS_IDLE && lamps == 2'b00;

  // checks
  `BSLC_AST_NXT(a_lamp_hold, !commit, $stable(lamps), "lamps moved without a commit")
  `BSLC_AST_NXT(a_class_eval_only, !ctl.eval, $stable(stat.cls), "class moved without evaluate")
  `BSLC_AST_NXT(a_tick_count, flash_tick, cnt_now == $past(cnt_now) + 8'd1, "tick not counted")
  `BSLC_AST_NXT(a_moving_off, moving_eval, idle_dark, "moving evaluate did not clear lamps")
  `BSLC_AST_IMP(a_commit_slot, commit, !out_vld_r || out_chan.ready, "commit while result held")

endmodule
